[hw/rtl/tfb_pkg.sv]
// Shared widths, types and codes of the tangent frame builder.
package tfb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int Z_W        = 32;
  localparam int TAN_W      = 18;
  localparam int BIT_W      = 32;
  localparam int EPS_W      = 16;
  localparam int SQ_W       = 2 * Z_W;
  localparam int N_W        = Z_W;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_W      = Z_W + FRAC_BITS + 2;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int T_W        = FRAC_BITS + 2;
  localparam int P_W        = Z_W + T_W;
  localparam int DF_W       = P_W + 1;
  localparam int R_W        = DF_W - FRAC_BITS;

  typedef logic [Z_W-1:0] mag_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_AXIS  = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  // Fields that ride along the whole chain
  typedef struct packed {
    logic signed [Z_W-1:0] z_x;
    logic signed [Z_W-1:0] z_y;
    logic signed [Z_W-1:0] z_z;
    logic                  want_x;
    logic                  want_y;
    logic                  kill;
    status_t               status;
  } side_t;

  // Side fields plus tangent magnitudes and signs
  typedef struct packed {
    side_t            side;
    mag_t [2:0]       mag;
    logic [2:0]       neg;
  } pay_t;

endpackage

[hw/rtl/tfb_sqrt_cell.sv]
// One cell of the square root chain: settles one result bit per cycle while en is high.
module tfb_sqrt_cell (
  input  logic                       clk,
  input  logic                       en,
  input  tfb_pkg::pay_t              pay_in,
  input  logic [tfb_pkg::SQ_W-1:0]   rem_in,
  input  logic [tfb_pkg::SQ_W-1:0]   res_in,
  input  logic [tfb_pkg::SQ_W-1:0]   bit_in,
  output tfb_pkg::pay_t              pay_out,
  output logic [tfb_pkg::SQ_W-1:0]   rem_out,
  output logic [tfb_pkg::SQ_W-1:0]   res_out,
  output logic [tfb_pkg::SQ_W-1:0]   bit_out
);
  import tfb_pkg::*;

  logic [SQ_W:0] trial;
  logic          take;

  // Try subtracting the current trial value
  assign trial = {1'b0, res_in} + {1'b0, bit_in};
  assign take  = {1'b0, rem_in} >= trial;

  // Advance one step and hand the state to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      pay_out <= pay_in;
      bit_out <= bit_in >> 2;
      if (take) begin
        rem_out <= rem_in - trial[SQ_W-1:0];
        res_out <= (res_in >> 1) + bit_in;
      end else begin
        rem_out <= rem_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

[hw/rtl/tfb_div_cell.sv]
// One cell of the divider chain: one quotient bit for each of three lanes.
module tfb_div_cell (
  input  logic                                clk,
  input  logic                                en,
  input  tfb_pkg::pay_t                       pay_in,
  input  logic [tfb_pkg::N_W-1:0]             n_in,
  input  logic [tfb_pkg::DIV_W-1:0]           d_in,
  input  logic [2:0][tfb_pkg::DIV_W-1:0]      rem_in,
  input  logic [2:0][tfb_pkg::Q_W-1:0]        q_in,
  output tfb_pkg::pay_t                       pay_out,
  output logic [tfb_pkg::N_W-1:0]             n_out,
  output logic [tfb_pkg::DIV_W-1:0]           d_out,
  output logic [2:0][tfb_pkg::DIV_W-1:0]      rem_out,
  output logic [2:0][tfb_pkg::Q_W-1:0]        q_out
);
  import tfb_pkg::*;

  // Compare and subtract the shifted divisor in each lane
  always_ff @(posedge clk) begin
    if (en) begin
      pay_out <= pay_in;
      n_out   <= n_in;
      d_out   <= d_in >> 1;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= d_in) begin
          rem_out[i] <= rem_in[i] - d_in;
          q_out[i]   <= {q_in[i][Q_W-2:0], 1'b1};
        end else begin
          rem_out[i] <= rem_in[i];
          q_out[i]   <= {q_in[i][Q_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

[hw/rtl/tangent_frame_builder.sv]
// Top level: builds a unit tangent and bitangent from a normal vector.
// Pipeline: 3 + 32 + 17 + 4 stages from input transaction to result.
// Throughput: one item per cycle while m_tready is high; a stage holds only while its successor is full and stalled.
// The 32 square root cells and 17 divider cells each settle one bit per stage.
// Reset clears all stage valid flags and sets epsilon to 1; data registers are not reset.
module tangent_frame_builder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [95:0]              s_tdata,   // z_x, z_y, z_z
  input  logic [3:0]               s_tuser,   // axis[1:0], want_x, want_y
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [151:0]             m_tdata,   // tan_x, tan_y, tan_z, bit_x, bit_y, bit_z, pad
  output logic [1:0]               m_tuser,   // status
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tfb_pkg::EPS_W-1:0] cfg_data
);
  import tfb_pkg::*;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam int S_DEC  = 0;
  localparam int S_SQ   = 1;
  localparam int S_SUM  = 2;
  localparam int S_SQRT = 3;
  localparam int S_DIV  = S_SQRT + SQRT_STEPS;
  localparam int S_T    = S_DIV + Q_W;
  localparam int S_MUL  = S_T + 1;
  localparam int S_DIF  = S_MUL + 1;
  localparam int S_OUT  = S_DIF + 1;
  localparam int NST    = S_OUT + 1;

  function automatic mag_t abs_z(input logic signed [Z_W-1:0] v);
    abs_z = v[Z_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  // Round half away from zero to the fraction and saturate to the output width
  function automatic logic [BIT_W-1:0] round_sat(input logic signed [DF_W-1:0] v);
    logic [DF_W-1:0] m;
    logic [DF_W-1:0] s;
    logic [R_W-1:0]  r;
    m = v[DF_W-1] ? DF_W'(-v) : DF_W'(v);
    s = m + (DF_W'(1) << (FRAC_BITS - 1));
    r = s[DF_W-1:FRAC_BITS];
    if (v[DF_W-1]) begin
      if ((r[R_W-1:BIT_W] != '0) || (r[BIT_W-1] && (r[BIT_W-2:0] != '0)))
        round_sat = {1'b1, {(BIT_W-1){1'b0}}};
      else
        round_sat = -r[BIT_W-1:0];
    end else begin
      if (r[R_W-1:BIT_W-1] != '0)
        round_sat = {1'b0, {(BIT_W-1){1'b1}}};
      else
        round_sat = r[BIT_W-1:0];
    end
  endfunction

  // Stage valid flags and ready chain
  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;
  logic [NST-1:0] vin;

  logic [EPS_W-1:0] epsilon;

  assign cfg_ready = 1'b1;

  // Hold the epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_W'(1);
    end else if (cfg_valid) begin
      epsilon <= cfg_data;
    end
  end

  generate
    for (genvar g = 0; g < NST; g++) begin : g_ctl
      if (g == 0) begin : g_first
        assign vin[g] = s_tvalid;
      end else begin : g_rest
        assign vin[g] = vld[g-1];
      end
      if (g == NST - 1) begin : g_last
        assign rdy[g] = !vld[g] || m_tready;
      end else begin : g_mid
        assign rdy[g] = !vld[g] || rdy[g+1];
      end
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[g] <= 1'b0;
        end else if (rdy[g]) begin
          vld[g] <= vin[g];
        end
      end
    end
  endgenerate

  assign s_tready = rdy[S_DEC];
  assign m_tvalid = vld[S_OUT];

  // Decode the axis, form tangent magnitudes and status
  logic signed [Z_W-1:0] in_x, in_y, in_z;
  logic [1:0]            in_axis;
  logic                  in_wx, in_wy;
  mag_t                  ax_x, ax_y, ax_z, dom;
  pay_t                  dec_next;
  pay_t                  dec;

  assign in_x    = s_tdata[Z_W-1:0];
  assign in_y    = s_tdata[2*Z_W-1:Z_W];
  assign in_z    = s_tdata[3*Z_W-1:2*Z_W];
  assign in_axis = s_tuser[1:0];
  assign in_wx   = s_tuser[2];
  assign in_wy   = s_tuser[3];
  assign ax_x    = abs_z(in_x);
  assign ax_y    = abs_z(in_y);
  assign ax_z    = abs_z(in_z);

  always_comb begin
    dec_next            = '0;
    dec_next.side.z_x   = in_x;
    dec_next.side.z_y   = in_y;
    dec_next.side.z_z   = in_z;
    dec_next.side.want_x = in_wx;
    dec_next.side.want_y = in_wy;
    dom                 = '0;
    case (in_axis)
      AX_X: begin
        dec_next.mag[0] = ax_y;
        dec_next.neg[0] = !in_y[Z_W-1] && (in_y != '0);
        dec_next.mag[1] = ax_x;
        dec_next.neg[1] = in_x[Z_W-1];
        dom             = ax_x;
      end
      AX_Y: begin
        dec_next.mag[1] = ax_z;
        dec_next.neg[1] = !in_z[Z_W-1] && (in_z != '0);
        dec_next.mag[2] = ax_y;
        dec_next.neg[2] = in_y[Z_W-1];
        dom             = ax_y;
      end
      AX_Z: begin
        dec_next.mag[0] = ax_z;
        dec_next.neg[0] = in_z[Z_W-1];
        dec_next.mag[2] = ax_x;
        dec_next.neg[2] = !in_x[Z_W-1] && (in_x != '0);
        dom             = ax_z;
      end
      default: begin
        dom = '0;
      end
    endcase
    if (!in_wx && !in_wy) begin
      dec_next.side.status = ST_OK;
      dec_next.side.kill   = 1'b1;
    end else if (in_axis != AX_X && in_axis != AX_Y && in_axis != AX_Z) begin
      dec_next.side.status = ST_AXIS;
      dec_next.side.kill   = 1'b1;
    end else if (dom < Z_W'(epsilon)) begin
      dec_next.side.status = ST_DEGEN;
      dec_next.side.kill   = 1'b1;
    end else begin
      dec_next.side.status = ST_OK;
      dec_next.side.kill   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_DEC]) begin
      dec <= dec_next;
    end
  end

  // Square each magnitude
  pay_t                  sq_p;
  logic [2:0][SQ_W-1:0]  sq;

  always_ff @(posedge clk) begin
    if (rdy[S_SQ]) begin
      sq_p <= dec;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= dec.mag[i] * dec.mag[i];
      end
    end
  end

  // Sum the squares
  pay_t            sum_p;
  logic [SQ_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rdy[S_SUM]) begin
      sum_p <= sq_p;
      sum   <= sq[0] + sq[1] + sq[2];
    end
  end

  // Square root chain
  pay_t            rt_pay [SQRT_STEPS+1];
  logic [SQ_W-1:0] rt_rem [SQRT_STEPS+1];
  logic [SQ_W-1:0] rt_res [SQRT_STEPS+1];
  logic [SQ_W-1:0] rt_bit [SQRT_STEPS+1];

  assign rt_pay[0] = sum_p;
  assign rt_rem[0] = sum;
  assign rt_res[0] = '0;
  assign rt_bit[0] = SQ_W'(1) << (SQ_W - 2);

  generate
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      tfb_sqrt_cell u_cell (
        .clk     (clk),
        .en      (rdy[S_SQRT+g]),
        .pay_in  (rt_pay[g]),
        .rem_in  (rt_rem[g]),
        .res_in  (rt_res[g]),
        .bit_in  (rt_bit[g]),
        .pay_out (rt_pay[g+1]),
        .rem_out (rt_rem[g+1]),
        .res_out (rt_res[g+1]),
        .bit_out (rt_bit[g+1])
      );
    end
  endgenerate

  // Divider chain: rounded quotient of magnitude and root
  pay_t                  dv_pay [Q_W+1];
  logic [N_W-1:0]        dv_n   [Q_W+1];
  logic [DIV_W-1:0]      dv_d   [Q_W+1];
  logic [2:0][DIV_W-1:0] dv_rem [Q_W+1];
  logic [2:0][Q_W-1:0]   dv_q   [Q_W+1];

  assign dv_pay[0] = rt_pay[SQRT_STEPS];
  assign dv_n[0]   = rt_res[SQRT_STEPS][N_W-1:0];
  assign dv_d[0]   = DIV_W'(dv_n[0]) << FRAC_BITS;
  assign dv_q[0]   = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = (DIV_W'(dv_pay[0].mag[i]) << FRAC_BITS) + DIV_W'(dv_n[0] >> 1);
    end
  end

  generate
    for (genvar g = 0; g < Q_W; g++) begin : g_div
      tfb_div_cell u_cell (
        .clk     (clk),
        .en      (rdy[S_DIV+g]),
        .pay_in  (dv_pay[g]),
        .n_in    (dv_n[g]),
        .d_in    (dv_d[g]),
        .rem_in  (dv_rem[g]),
        .q_in    (dv_q[g]),
        .pay_out (dv_pay[g+1]),
        .n_out   (dv_n[g+1]),
        .d_out   (dv_d[g+1]),
        .rem_out (dv_rem[g+1]),
        .q_out   (dv_q[g+1])
      );
    end
  endgenerate

  // Clamp, apply sign, zero on an empty root
  side_t                 t_side;
  logic signed [T_W-1:0] t_v [3];
  logic [Q_W-1:0]        one;
  logic [Q_W-1:0]        qc [3];

  assign one = Q_W'(1) << FRAC_BITS;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[Q_W][i] > one) ? one : dv_q[Q_W][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_T]) begin
      t_side <= dv_pay[Q_W].side;
      for (int i = 0; i < 3; i++) begin
        if (dv_n[Q_W] == '0)
          t_v[i] <= '0;
        else if (dv_pay[Q_W].neg[i])
          t_v[i] <= -$signed({1'b0, qc[i]});
        else
          t_v[i] <= $signed({1'b0, qc[i]});
      end
    end
  end

  // Cross product terms
  side_t                 m_side;
  logic signed [T_W-1:0] m_t [3];
  logic signed [P_W-1:0] pm [6];

  always_ff @(posedge clk) begin
    if (rdy[S_MUL]) begin
      m_side <= t_side;
      for (int i = 0; i < 3; i++) begin
        m_t[i] <= t_v[i];
      end
      pm[0] <= t_side.z_y * t_v[2];
      pm[1] <= t_side.z_z * t_v[1];
      pm[2] <= t_side.z_z * t_v[0];
      pm[3] <= t_side.z_x * t_v[2];
      pm[4] <= t_side.z_x * t_v[1];
      pm[5] <= t_side.z_y * t_v[0];
    end
  end

  // Differences of the terms
  side_t                  f_side;
  logic signed [T_W-1:0]  f_t [3];
  logic signed [DF_W-1:0] df [3];

  always_ff @(posedge clk) begin
    if (rdy[S_DIF]) begin
      f_side <= m_side;
      for (int i = 0; i < 3; i++) begin
        f_t[i] <= m_t[i];
        df[i]  <= DF_W'(pm[2*i]) - DF_W'(pm[2*i+1]);
      end
    end
  end

  // Output register: mask by request and status
  logic [TAN_W-1:0] o_tan [3];
  logic [BIT_W-1:0] o_bit [3];
  status_t          o_status;

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      o_status <= f_side.status;
      for (int i = 0; i < 3; i++) begin
        o_tan[i] <= (!f_side.kill && f_side.want_x) ? TAN_W'(f_t[i]) : '0;
        o_bit[i] <= (!f_side.kill && f_side.want_y) ? round_sat(df[i]) : '0;
      end
    end
  end

  assign m_tdata = {2'b00, o_bit[2], o_bit[1], o_bit[0], o_tan[2], o_tan[1], o_tan[0]};
  assign m_tuser = o_status;

endmodule
